// ----- src/stsce_pkg.sv -----
// ----------------------------------------------------------------------------
// stsce_pkg: shared types and constants for the sensor-to-current encoder
// Register map, configuration record, sequencer states and divider handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stsce_pkg;

  localparam int MAX_STEPS = 16;
  localparam int STEP_W    = 4;
  localparam int SAMPLE_W  = 16;
  localparam int TAG_W     = 32;
  localparam int CUR_W     = 32;
  localparam int QUO_W     = 17;
  localparam int RATE_W    = 17;
  localparam int OFF_W     = 10;
  localparam int SPT_W     = 5;
  localparam int PHASE_W   = 16;

  localparam logic [OFF_W-1:0]   PHASE_OFF_MAX = 10'd999;
  localparam logic [PHASE_W-1:0] PHASE_SCALE   = 16'd1000;

  // operating modes; the unused code behaves as rate mode
  localparam logic [1:0] MODE_LINEAR  = 2'd0;
  localparam logic [1:0] MODE_BIPOLAR = 2'd1;
  localparam logic [1:0] MODE_RATE    = 2'd2;

  typedef enum logic [2:0] {
    REG_MODE         = 3'd0,
    REG_AMPLITUDE    = 3'd1,
    REG_BIAS         = 3'd2,
    REG_MAX_RATE     = 3'd3,
    REG_PHASE_INIT   = 3'd4,
    REG_SENSOR_MIN   = 3'd5,
    REG_SENSOR_MAX   = 3'd6,
    REG_STEPS        = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]                 mode;
    logic signed [CUR_W-1:0]    amplitude;
    logic signed [CUR_W-1:0]    bias;
    logic [RATE_W-1:0]          max_rate;
    logic [OFF_W-1:0]           phase_init;
    logic signed [SAMPLE_W-1:0] sensor_min;
    logic signed [SAMPLE_W-1:0] sensor_max;
    logic [SPT_W-1:0]           steps_per_tick;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    mode:           2'd0,
    amplitude:      32'sh0001_0000,
    bias:           32'sh0000_0000,
    max_rate:       17'h1_0000,
    phase_init:     10'd0,
    sensor_min:     16'sh8000,
    sensor_max:     16'sh7FFF,
    steps_per_tick: 5'd1
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RELOAD,
    ST_DIV,
    ST_MUL,
    ST_SAT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic               start;
    logic [PHASE_W-1:0] num;
    logic [PHASE_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

// ----- src/sensor_to_spike_current_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// sensor_to_spike_current_encoder_unit: sample to Q16.16 current encoder
// Path: accept, normalise on the shared divider, multiply, saturate, emit words.
// No new sample is taken until the last word of the current one is loaded; an error gives one word.
// Reset: registers to defaults, phase to zero; a write reloads the phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sensor_to_spike_current_encoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] sensor_sample, [47:16] frame_tag
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [31:0] current, [35:32] step_index,
                                  // [67:36] tag_out, [71:68] zero
  output logic        out_tlast,  // last_step
  output logic        out_tuser,  // status
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import stsce_pkg::*;

  localparam logic [STEP_W-1:0] LAST_IDX_MAX = STEP_W'(MAX_STEPS - 1);
  localparam logic [SPT_W-1:0]  STEPS_MAX    = SPT_W'(MAX_STEPS);

  cfg_t     cfg;
  logic     cfg_upd;
  div_req_t div_req;
  div_rsp_t div_rsp;

  stsce_cfg_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg),
    .upd         (cfg_upd)
  );

  // One divider serves both the sample normalisation and the phase reload
  stsce_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Sequencer and working registers
  state_t                 state_r, state_nxt;
  logic [TAG_W-1:0]       tag_r, tag_nxt;
  logic                   err_r, err_nxt;
  logic [QUO_W-1:0]       n_r, n_nxt;
  logic [STEP_W-1:0]      last_idx_r, last_idx_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic signed [50:0]     prod_r, prod_nxt;
  logic [CUR_W-1:0]       cur_r, cur_nxt;
  logic [RATE_W-1:0]      inc_r, inc_nxt;
  logic [PHASE_W-1:0]     phase_r, phase_nxt;

  // Output word register
  logic                   out_valid_r, out_valid_nxt;
  logic [CUR_W-1:0]       out_cur_r, out_cur_nxt;
  logic [STEP_W-1:0]      out_step_r, out_step_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_status_r, out_status_nxt;
  logic [TAG_W-1:0]       out_tag_r, out_tag_nxt;

  // Input word fields and limit check
  logic signed [SAMPLE_W-1:0] in_sample;
  logic [TAG_W-1:0]           in_tag;
  logic                       in_fire;
  logic                       in_range;
  logic [SAMPLE_W:0]          num_w;
  logic [SAMPLE_W:0]          den_w;
  logic [OFF_W-1:0]           off_clamp;
  logic [STEP_W-1:0]          last_idx_w;

  // Shared multiplier and result shaping
  logic signed [32:0]         mul_a;
  logic signed [17:0]         mul_b;
  logic [18:0]                bip_w;
  logic signed [50:0]         prod_w;
  logic signed [32:0]         sh_w;
  logic signed [33:0]         sum_w;
  logic [CUR_W-1:0]           sat_w;
  logic [PHASE_W+1:0]         ph_sum;
  logic                       wrap;
  logic                       slot_free;
  logic                       rate_mode;

  assign in_sample = $signed(in_tdata[15:0]);
  assign in_tag    = in_tdata[47:16];
  assign in_fire   = in_tvalid & in_tready;
  assign in_range  = (in_sample >= cfg.sensor_min) && (in_sample <= cfg.sensor_max);
  assign num_w     = {in_sample[15], in_sample} - {cfg.sensor_min[15], cfg.sensor_min};
  assign den_w     = {cfg.sensor_max[15], cfg.sensor_max} - {cfg.sensor_min[15], cfg.sensor_min};
  assign off_clamp = (cfg.phase_init > PHASE_OFF_MAX) ? PHASE_OFF_MAX : cfg.phase_init;

  // Clamp the step count to 1..MAX_STEPS and hold it as the last step index
  always_comb begin
    if (cfg.steps_per_tick == '0) begin
      last_idx_w = '0;
    end else if (cfg.steps_per_tick > STEPS_MAX) begin
      last_idx_w = LAST_IDX_MAX;
    end else begin
      last_idx_w = STEP_W'(cfg.steps_per_tick - SPT_W'(1));
    end
  end

  // Operand select: gain times n, gain times (2n - 1.0), or rate times n
  always_comb begin
    bip_w     = {1'b0, n_r, 1'b0} - 19'h1_0000;
    rate_mode = 1'b0;
    case (cfg.mode)
      MODE_LINEAR: begin
        mul_a = {cfg.amplitude[31], cfg.amplitude};
        mul_b = $signed({1'b0, n_r});
      end
      MODE_BIPOLAR: begin
        mul_a = {cfg.amplitude[31], cfg.amplitude};
        mul_b = $signed(bip_w[17:0]);
      end
      default: begin
        mul_a     = $signed({16'd0, cfg.max_rate});
        mul_b     = $signed({1'b0, n_r});
        rate_mode = 1'b1;
      end
    endcase
  end

  assign prod_w = 51'(mul_a) * 51'(mul_b);

  // Floor divide by 65536 (arithmetic shift), add bias, saturate to 32 bits
  assign sh_w  = prod_r[48:16];
  assign sum_w = {sh_w[32], sh_w} + {{2{cfg.bias[31]}}, cfg.bias};
  always_comb begin
    if (sum_w[33:31] == 3'b000 || sum_w[33:31] == 3'b111) begin
      sat_w = sum_w[31:0];
    end else if (sum_w[33]) begin
      sat_w = 32'h8000_0000;
    end else begin
      sat_w = 32'h7FFF_FFFF;
    end
  end

  // Rate phase: advance by the increment, fire on wrap past 1.0
  assign ph_sum = {2'b00, phase_r} + {1'b0, inc_r};
  assign wrap   = ph_sum[PHASE_W+1] | ph_sum[PHASE_W];

  // The output word may be loaded when empty or when being taken this cycle
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    tag_nxt        = tag_r;
    err_nxt        = err_r;
    n_nxt          = n_r;
    last_idx_nxt   = last_idx_r;
    step_nxt       = step_r;
    prod_nxt       = prod_r;
    cur_nxt        = cur_r;
    inc_nxt        = inc_r;
    phase_nxt      = phase_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_cur_nxt    = out_cur_r;
    out_step_nxt   = out_step_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    out_tag_nxt    = out_tag_r;
    div_req        = '0;
    in_tready      = (state_r == ST_IDLE) && !cfg_upd;

    if (cfg_upd) begin
      // any register write restarts the phase reload: start * 65536 / 1000
      div_req.start = 1'b1;
      div_req.num   = {6'd0, off_clamp};
      div_req.den   = PHASE_SCALE;
      state_nxt     = ST_RELOAD;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            tag_nxt      = in_tag;
            last_idx_nxt = last_idx_w;
            if (!in_range) begin
              err_nxt   = 1'b1;
              state_nxt = ST_EMIT;
            end else begin
              err_nxt = 1'b0;
              if (den_w == '0) begin
                n_nxt     = '0;
                state_nxt = ST_MUL;
              end else begin
                div_req.start = 1'b1;
                div_req.num   = num_w[15:0];
                div_req.den   = den_w[15:0];
                state_nxt     = ST_DIV;
              end
            end
          end
        end
        ST_RELOAD: begin
          if (div_rsp.done) begin
            phase_nxt = div_rsp.quo[PHASE_W-1:0];
            state_nxt = ST_IDLE;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            n_nxt     = div_rsp.quo;
            state_nxt = ST_MUL;
          end
        end
        ST_MUL: begin
          prod_nxt  = prod_w;
          state_nxt = ST_SAT;
        end
        ST_SAT: begin
          cur_nxt   = sat_w;
          inc_nxt   = prod_r[32:16];
          step_nxt  = '0;
          state_nxt = ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid_nxt  = 1'b1;
            out_tag_nxt    = tag_r;
            out_status_nxt = err_r;
            if (err_r) begin
              // single error word, phase untouched
              out_cur_nxt  = '0;
              out_step_nxt = '0;
              out_last_nxt = 1'b1;
              state_nxt    = ST_IDLE;
            end else begin
              out_step_nxt = step_r;
              out_last_nxt = step_r == last_idx_r;
              if (rate_mode) begin
                phase_nxt   = ph_sum[PHASE_W-1:0];
                out_cur_nxt = wrap ? cfg.amplitude : '0;
              end else begin
                out_cur_nxt = cur_r;
              end
              if (step_r == last_idx_r) begin
                state_nxt = ST_IDLE;
              end else begin
                step_nxt = step_r + STEP_W'(1);
              end
            end
          end
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      phase_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  // Payload registers: no reset needed
  always_ff @(posedge clk) begin
    tag_r        <= tag_nxt;
    err_r        <= err_nxt;
    n_r          <= n_nxt;
    last_idx_r   <= last_idx_nxt;
    step_r       <= step_nxt;
    prod_r       <= prod_nxt;
    cur_r        <= cur_nxt;
    inc_r        <= inc_nxt;
    out_cur_r    <= out_cur_nxt;
    out_step_r   <= out_step_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
    out_tag_r    <= out_tag_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_tag_r, out_step_r, out_cur_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_status_r;

endmodule

// ----- src/stsce_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// stsce_cfg_regs: configuration register file
// APB-style write/read port; flags every write in the next cycle for reload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stsce_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [4:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output stsce_pkg::cfg_t   cfg,
  output logic              upd
);
  import stsce_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  logic     upd_r;
  logic     wr_en;
  reg_idx_t idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign idx        = reg_idx_t'(cfg_paddr[4:2]);
  assign cfg        = cfg_r;
  assign upd        = upd_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_MODE:         cfg_nxt.mode           = cfg_pwdata[1:0];
        REG_AMPLITUDE:    cfg_nxt.amplitude      = $signed(cfg_pwdata);
        REG_BIAS:         cfg_nxt.bias           = $signed(cfg_pwdata);
        REG_MAX_RATE:     cfg_nxt.max_rate       = cfg_pwdata[RATE_W-1:0];
        REG_PHASE_INIT:   cfg_nxt.phase_init     = cfg_pwdata[OFF_W-1:0];
        REG_SENSOR_MIN:   cfg_nxt.sensor_min     = $signed(cfg_pwdata[SAMPLE_W-1:0]);
        REG_SENSOR_MAX:   cfg_nxt.sensor_max     = $signed(cfg_pwdata[SAMPLE_W-1:0]);
        REG_STEPS:        cfg_nxt.steps_per_tick = cfg_pwdata[SPT_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:         cfg_prdata = {30'd0, cfg_r.mode};
      REG_AMPLITUDE:    cfg_prdata = cfg_r.amplitude;
      REG_BIAS:         cfg_prdata = cfg_r.bias;
      REG_MAX_RATE:     cfg_prdata = {15'd0, cfg_r.max_rate};
      REG_PHASE_INIT:   cfg_prdata = {22'd0, cfg_r.phase_init};
      REG_SENSOR_MIN:   cfg_prdata = {{16{cfg_r.sensor_min[15]}}, cfg_r.sensor_min};
      REG_SENSOR_MAX:   cfg_prdata = {{16{cfg_r.sensor_max[15]}}, cfg_r.sensor_max};
      REG_STEPS:        cfg_prdata = {27'd0, cfg_r.steps_per_tick};
      default:          cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
      upd_r <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
      upd_r <= wr_en;
    end
  end

endmodule

// ----- src/stsce_divider.sv -----
// ----------------------------------------------------------------------------
// stsce_divider: shared restoring divider
// Computes floor(num * 65536 / den) for num <= den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stsce_divider (
  input  logic                clk,
  input  logic                rst_n,
  input  stsce_pkg::div_req_t req,
  output stsce_pkg::div_rsp_t rsp
);
  import stsce_pkg::*;

  localparam logic [4:0] LAST_ITER = 5'(QUO_W - 1);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic [QUO_W-1:0]   rem_r, rem_nxt;
  logic [QUO_W-1:0]   quo_r, quo_nxt;
  logic [PHASE_W-1:0] den_r, den_nxt;
  logic [QUO_W-1:0]   trial;
  logic               ge;
  logic               last;

  always_comb begin
    // first step compares the numerator itself, later ones the doubled remainder
    trial    = (cnt_r == 5'd0) ? rem_r : {rem_r[QUO_W-2:0], 1'b0};
    ge       = trial >= {1'b0, den_r};
    last     = cnt_r == LAST_ITER;
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    done_nxt = 1'b0;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 5'd0;
      rem_nxt  = {1'b0, req.num};
      quo_nxt  = '0;
      den_nxt  = req.den;
    end else if (busy_r) begin
      rem_nxt = ge ? (trial - {1'b0, den_r}) : trial;
      quo_nxt = {quo_r[QUO_W-2:0], ge};
      cnt_nxt = cnt_r + 5'd1;
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 5'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

// ----- sim/sensor_to_spike_current_encoder_unit_tb.sv -----
// ----------------------------------------------------------------------------
// sensor_to_spike_current_encoder_unit_tb: self-checking bench for the encoder
// Drives samples on the input stream, writes the registers over the config
// port while the block is idle, and predicts every result word in step with
// the accepted samples. Each result word is compared field by field with the
// oldest prediction. Both streams idle at random, with one long receiver
// hold-off and a final stretch with no idling at all.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sensor_to_spike_current_encoder_unit_tb;
  import stsce_pkg::*;

  // settle time after a register write, long enough for the phase reload
  localparam int RELOAD_WAIT = 30;
  // quiet cycles after the last expected word before touching the registers
  localparam int TAIL_WAIT   = 40;
  // length of the receiver hold-off used to back up the block
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [31:0] current;
    logic [3:0]  step;
    logic        last;
    logic        status;
    logic [31:0] tag;
  } step_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;     // [15:0] sensor_sample, [47:16] frame_tag
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;         // [31:0] current, [35:32] step_index,
                                  // [67:36] tag_out, [71:68] zero
  logic        out_tlast;         // last_step
  logic        out_tuser;         // status
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // prediction state: register copy, rate phase and the queue of pending words
  cfg_t        enc_cfg = CFG_RESET;
  logic [15:0] enc_phase = '0;
  step_word_t  pending_words[$];

  int   error_count = 0;
  bit   idle_on = 1'b1;
  logic holding = 1'b0;
  int   ready_stall_left = 0;
  event hold_off_req;

  sensor_to_spike_current_encoder_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic logic [31:0] clamp_current(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // phase restarts at the start phase in thousandths of a cycle, capped at 999
  function automatic void reload_phase();
    int unsigned off;
    off = (enc_cfg.phase_init > PHASE_OFF_MAX) ? PHASE_OFF_MAX : enc_cfg.phase_init;
    enc_phase = 16'((off * 65536) / PHASE_SCALE);
  endfunction

  function automatic void encode_sample(logic [15:0] raw, logic [31:0] tag);
    int         smp;
    int         lo;
    int         hi;
    int         steps;
    longint     norm;
    longint     prod;
    longint     sum;
    step_word_t w;
    smp = $signed(raw);
    lo  = $signed(enc_cfg.sensor_min);
    hi  = $signed(enc_cfg.sensor_max);
    w.tag = tag;
    // out of limits (also every sample when the limits are reversed):
    // one error word, phase untouched
    if (smp < lo || smp > hi) begin
      w.current = '0;
      w.step    = '0;
      w.last    = 1'b1;
      w.status  = 1'b1;
      pending_words.push_back(w);
      return;
    end
    if (hi == lo) norm = 0;
    else          norm = (longint'(smp - lo) * 65536) / longint'(hi - lo);
    steps = enc_cfg.steps_per_tick;
    if (steps == 0) steps = 1;
    if (steps > MAX_STEPS) steps = MAX_STEPS;
    for (int k = 0; k < steps; k++) begin
      case (enc_cfg.mode)
        MODE_LINEAR: begin
          prod = longint'($signed(enc_cfg.amplitude)) * norm;
          w.current = clamp_current(longint'($signed(enc_cfg.bias)) + (prod >>> 16));
        end
        MODE_BIPOLAR: begin
          prod = longint'($signed(enc_cfg.amplitude)) * (2 * norm - 65536);
          w.current = clamp_current(longint'($signed(enc_cfg.bias)) + (prod >>> 16));
        end
        default: begin
          // rate mode, and the spare mode code behaves the same
          sum = longint'(enc_phase) + ((norm * longint'(enc_cfg.max_rate)) >>> 16);
          enc_phase = sum[15:0];
          w.current = (sum >= 65536) ? enc_cfg.amplitude : 32'h0;
        end
      endcase
      w.step   = k[3:0];
      w.last   = (k == steps - 1);
      w.status = 1'b0;
      pending_words.push_back(w);
    end
  endfunction

  // predict at the edge that accepts a sample
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) encode_sample(in_tdata[15:0], in_tdata[47:16]);
  end

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : check_words
    step_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word, tag", out_tdata[67:36], '0);
      end else begin
        want = pending_words.pop_front();
        if (out_tdata[31:0] !== want.current)
          report_mismatch("current", out_tdata[31:0], want.current);
        if (out_tdata[35:32] !== want.step)
          report_mismatch("step_index", 32'(out_tdata[35:32]), 32'(want.step));
        if (out_tlast !== want.last)
          report_mismatch("last_step", 32'(out_tlast), 32'(want.last));
        if (out_tuser !== want.status)
          report_mismatch("status", 32'(out_tuser), 32'(want.status));
        if (out_tdata[67:36] !== want.tag)
          report_mismatch("tag_out", out_tdata[67:36], want.tag);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, or a long hold-off on request
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    if (holding) begin
      out_tready <= 1'b0;
    end else if (ready_stall_left != 0) begin
      ready_stall_left <= ready_stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      ready_stall_left <= $urandom_range(0, 18);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // count the hold-off here so the sender keeps offering words meanwhile
  always begin
    @(hold_off_req);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Sender and register access; every task starts and ends on a rising edge
  // --------------------------------------------------------------------------

  // offer one sample and hold it until accepted; valid stays high afterwards
  task automatic send_sample(logic [15:0] smp, logic [31:0] tag);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {tag, smp};
    do @(posedge clk); while (!in_tready);
  endtask

  // drop valid and wait until every expected word has come, plus a margin
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    // register taken at this edge
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_MODE:         enc_cfg.mode           = val[1:0];
      REG_AMPLITUDE:    enc_cfg.amplitude      = val;
      REG_BIAS:         enc_cfg.bias           = val;
      REG_MAX_RATE:     enc_cfg.max_rate       = val[16:0];
      REG_PHASE_INIT:   enc_cfg.phase_init     = val[9:0];
      REG_SENSOR_MIN:   enc_cfg.sensor_min     = val[15:0];
      REG_SENSOR_MAX:   enc_cfg.sensor_max     = val[15:0];
      REG_STEPS:        enc_cfg.steps_per_tick = val[4:0];
      default: ;
    endcase
    reload_phase();
    // hold off until the phase reload has finished
    repeat (RELOAD_WAIT) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_gain();
    if ($urandom_range(0, 1) == 0) return $urandom;
    return 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
  endfunction

  // new random setting over all eight registers, extremes now and then
  task automatic randomise_config();
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] t;
    int                 pick;
    a = 16'($urandom);
    b = 16'($urandom);
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      b = a;                                   // equal limits
    end else if (pick == 1) begin
      if (a < b) begin t = a; a = b; b = t; end // reversed limits
      if (a == b) a = b + 16'sd1;
    end else if (pick == 2) begin
      a = 16'sh8000;                           // full input range
      b = 16'sh7FFF;
    end else if (a > b) begin
      t = a; a = b; b = t;
    end
    write_reg(REG_MODE, 32'($urandom_range(0, 3)));
    write_reg(REG_AMPLITUDE, pick_gain());
    write_reg(REG_BIAS, pick_gain());
    pick = $urandom_range(0, 9);
    if (pick == 0)      write_reg(REG_MAX_RATE, 32'h0);
    else if (pick == 1) write_reg(REG_MAX_RATE, 32'($urandom_range(65537, 131071)));
    else                write_reg(REG_MAX_RATE, 32'($urandom_range(1, 65536)));
    write_reg(REG_PHASE_INIT, 32'($urandom_range(0, 1023)));
    write_reg(REG_SENSOR_MIN, 32'(a));
    write_reg(REG_SENSOR_MAX, 32'(b));
    // mostly short ticks to keep the run brisk, the full span sometimes
    if ($urandom_range(0, 4) == 0) write_reg(REG_STEPS, 32'($urandom_range(0, 31)));
    else                           write_reg(REG_STEPS, 32'($urandom_range(1, 4)));
  endtask

  // mostly samples inside the limits, some on them, some anywhere
  function automatic logic [15:0] pick_sample();
    int lo;
    int hi;
    int pick;
    lo = $signed(enc_cfg.sensor_min);
    hi = $signed(enc_cfg.sensor_max);
    pick = $urandom_range(0, 19);
    if (lo > hi || pick < 3) return 16'($urandom);
    if (pick == 3) return 16'(lo);
    if (pick == 4) return 16'(hi);
    return 16'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) send_sample(pick_sample(), $urandom);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // reset setting: linear, unit gain, full range, one word per sample
  task automatic test_reset_defaults();
    send_sample(16'sh8000, 32'h0000_0000);
    send_sample(16'sh7FFF, 32'hFFFF_FFFF);
    send_sample(16'sh0000, 32'h5555_5555);
    send_sample(16'shFFFF, 32'hAAAA_AAAA);
    drain();
  endtask

  // both current modes driven into saturation, linear at either end, bipolar at the low end
  task automatic test_current_saturation();
    write_reg(REG_STEPS, 32'd16);
    write_reg(REG_AMPLITUDE, 32'h7FFF_FFFF);
    write_reg(REG_BIAS, 32'h7FFF_FFFF);
    send_sample(16'sh7FFF, 32'h0000_0101);
    drain();
    write_reg(REG_AMPLITUDE, 32'h8000_0000);
    write_reg(REG_BIAS, 32'h8000_0000);
    send_sample(16'sh7FFF, 32'h0000_0102);
    drain();
    write_reg(REG_MODE, 32'(MODE_BIPOLAR));
    write_reg(REG_STEPS, 32'd3);
    send_sample(16'sh7FFF, 32'h0000_0103);
    send_sample(16'sh8000, 32'h0000_0104);
    send_sample(16'sh0000, 32'h0000_0105);
    drain();
  endtask

  // rate pulses: negative pulse current, capped start phase, zero and oversized
  // rate, then the spare mode code
  task automatic test_rate_pulses();
    write_reg(REG_MODE, 32'(MODE_RATE));
    write_reg(REG_AMPLITUDE, 32'hFFFF_FFFB);
    write_reg(REG_MAX_RATE, 32'd65536);
    write_reg(REG_STEPS, 32'd16);
    write_reg(REG_PHASE_INIT, 32'd1023);
    send_sample(16'sh0000, 32'h0000_0201);
    drain();
    write_reg(REG_MAX_RATE, 32'h1_FFFF);
    send_sample(16'sh7FFF, 32'h0000_0202);
    drain();
    write_reg(REG_MAX_RATE, 32'h0);
    send_sample(16'sh7FFF, 32'h0000_0203);
    drain();
    write_reg(REG_MAX_RATE, 32'd40000);
    write_reg(REG_MODE, 32'd3);
    send_sample(16'sh4000, 32'h0000_0204);
    drain();
  endtask

  // limits: samples just outside keep the phase; equal and reversed limits
  task automatic test_sensor_limits();
    write_reg(REG_STEPS, 32'd2);
    write_reg(REG_AMPLITUDE, 32'd7);
    write_reg(REG_SENSOR_MIN, 32'hFFFF_FF9C);   // -100
    write_reg(REG_SENSOR_MAX, 32'd100);
    send_sample(16'sd100, 32'h0000_0301);
    send_sample(-16'sd101, 32'h0000_0302);
    send_sample(16'sd101, 32'h0000_0303);
    send_sample(16'sd100, 32'h0000_0304);
    drain();
    write_reg(REG_MODE, 32'(MODE_LINEAR));
    write_reg(REG_SENSOR_MIN, 32'd5);
    write_reg(REG_SENSOR_MAX, 32'd5);
    send_sample(16'sd5, 32'h0000_0305);
    send_sample(16'sd4, 32'h0000_0306);
    drain();
    write_reg(REG_SENSOR_MIN, 32'd10);
    write_reg(REG_SENSOR_MAX, 32'hFFFF_FFF6);   // -10
    send_sample(16'sd0, 32'h0000_0307);
    drain();
  endtask

  // step counts of zero and above the maximum
  task automatic test_step_counts();
    write_reg(REG_SENSOR_MIN, 32'h0000_8000);
    write_reg(REG_SENSOR_MAX, 32'h0000_7FFF);
    write_reg(REG_STEPS, 32'd0);
    send_sample(16'sh1234, 32'h0000_0401);
    drain();
    write_reg(REG_STEPS, 32'd31);
    send_sample(16'shEDCB, 32'h0000_0402);
    drain();
    write_reg(REG_STEPS, 32'd17);
    send_sample(16'sh0F0F, 32'h0000_0403);
    drain();
  endtask

  task automatic test_random_settings(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      randomise_config();
      send_random(per_phase);
      drain();
    end
  endtask

  // hold the result side off while samples keep coming, so the input stalls
  task automatic test_backpressure();
    write_reg(REG_MODE, 32'(MODE_LINEAR));
    write_reg(REG_SENSOR_MIN, 32'h0000_8000);
    write_reg(REG_SENSOR_MAX, 32'h0000_7FFF);
    write_reg(REG_STEPS, 32'd16);
    idle_on = 1'b0;
    -> hold_off_req;
    send_random(20);
    drain();
    idle_on = 1'b1;
  endtask

  // closing stretch at full rate on both sides
  task automatic test_full_rate();
    idle_on = 1'b0;
    randomise_config();
    send_random(50);
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    reload_phase();
    test_reset_defaults();
    test_current_saturation();
    test_rate_pulses();
    test_sensor_limits();
    test_step_counts();
    test_random_settings(10, 30);
    test_backpressure();
    test_full_rate();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- files.f -----
src/stsce_pkg.sv
src/stsce_cfg_regs.sv
src/stsce_divider.sv
src/sensor_to_spike_current_encoder_unit.sv
sim/sensor_to_spike_current_encoder_unit_tb.sv
